// File: rtl/directional_pair_filter_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the directional pair filter unit
// Each macro expects signals named clk and arst_n in the scope of use.
// ----------------------------------------------------------------------------
`ifndef DIRECTIONAL_PAIR_FILTER_UNIT_ASSERT_SVH
`define DIRECTIONAL_PAIR_FILTER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DPF_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DPF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/dpf_pkg.sv
// ----------------------------------------------------------------------------
// dpf_pkg
// Shared widths, register codes and stage counts of the pair filter.
// ----------------------------------------------------------------------------
package dpf_pkg;

	localparam int DELTA_W = 24;
	localparam int DIR_W = 16;
	localparam int COS_W = 17;
	localparam int CYL_W = 25;
	localparam int BENCH_W = 24;
	localparam int DIST_W = 26;
	localparam int MAX_DIMS = 3;

	// Squared length of the delta vector and its floor square root.
	localparam int NORM_W = 48;
	localparam int ROOT_W = NORM_W / 2;

	// The square root retires two result bits per pipeline stage.
	localparam int SQRT_BITS_PER_STAGE = 2;
	localparam int SQRT_STAGES = ROOT_W / SQRT_BITS_PER_STAGE;

	localparam int PADDR_W = 5;

	typedef enum logic [2:0] {
		REG_DIMS   = 3'd0,
		REG_DIR_X  = 3'd1,
		REG_DIR_Y  = 3'd2,
		REG_DIR_Z  = 3'd3,
		REG_COS    = 3'd4,
		REG_CYL    = 3'd5,
		REG_BENCH  = 3'd6,
		REG_ASYM   = 3'd7
	} reg_idx_t;

endpackage

// File: rtl/dpf_isqrt.sv
// ----------------------------------------------------------------------------
// dpf_isqrt
// Pipelined floor square root, two result bits per stage, restoring form.
// ----------------------------------------------------------------------------
module dpf_isqrt (
	input  logic                                 clk,
	input  logic [dpf_pkg::SQRT_STAGES-1:0]      adv,
	input  logic [dpf_pkg::NORM_W-1:0]           rad_in,
	output logic [dpf_pkg::ROOT_W-1:0]           root_out
);
	import dpf_pkg::*;

	localparam int REM_W = ROOT_W + 2;

	logic [NORM_W-1:0] rad_s  [SQRT_STAGES];
	logic [REM_W-1:0]  rem_s  [SQRT_STAGES];
	logic [ROOT_W-1:0] root_s [SQRT_STAGES];

	logic [NORM_W-1:0] rad_pv  [SQRT_STAGES];
	logic [REM_W-1:0]  rem_pv  [SQRT_STAGES];
	logic [ROOT_W-1:0] root_pv [SQRT_STAGES];

	logic [NORM_W-1:0] rad_nx  [SQRT_STAGES];
	logic [REM_W-1:0]  rem_nx  [SQRT_STAGES];
	logic [ROOT_W-1:0] root_nx [SQRT_STAGES];

	// Inputs of each stage: the radicand for the first, the previous stage
	// for the others.
	always_comb begin
		rad_pv[0] = rad_in;
		rem_pv[0] = '0;
		root_pv[0] = '0;
		for (int k = 1; k < SQRT_STAGES; k++) begin
			rad_pv[k] = rad_s[k-1];
			rem_pv[k] = rem_s[k-1];
			root_pv[k] = root_s[k-1];
		end
	end

	always_comb begin
		logic [NORM_W-1:0] rad;
		logic [REM_W-1:0] rem;
		logic [ROOT_W-1:0] root;
		logic [REM_W+1:0] trial_rem;
		logic [REM_W+1:0] trial_sub;
		for (int k = 0; k < SQRT_STAGES; k++) begin
			rad = rad_pv[k];
			rem = rem_pv[k];
			root = root_pv[k];
			for (int j = 0; j < SQRT_BITS_PER_STAGE; j++) begin
				trial_rem = {rem, rad[NORM_W-1 -: 2]};
				trial_sub = (REM_W+2)'({root, 2'b01});
				if (trial_rem >= trial_sub) begin
					rem = REM_W'(trial_rem - trial_sub);
					root = {root[ROOT_W-2:0], 1'b1};
				end else begin
					rem = REM_W'(trial_rem);
					root = {root[ROOT_W-2:0], 1'b0};
				end
				rad = {rad[NORM_W-3:0], 2'b00};
			end
			rad_nx[k] = rad;
			rem_nx[k] = rem;
			root_nx[k] = root;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < SQRT_STAGES; k++) begin
			if (adv[k]) begin
				rad_s[k] <= rad_nx[k];
				rem_s[k] <= rem_nx[k];
				root_s[k] <= root_nx[k];
			end
		end
	end

	assign root_out = root_s[SQRT_STAGES-1];

endmodule

// File: rtl/directional_pair_filter_unit.sv
// ----------------------------------------------------------------------------
// directional_pair_filter_unit
// Classifies a pair increment against a direction cone, cylinder and bench,
// and reports its floor length, signed for opposite pairs in asymmetric mode.
// ----------------------------------------------------------------------------
// Throughput is one pair per cycle while the result channel is not stalled;
// the square root pipeline, twelve stages of two root bits each, sets the
// depth.
// Reset clears all pipeline valid bits and loads the register defaults:
// three axes, direction along x, all tolerance tests disabled.
module directional_pair_filter_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	// Pair channel.
	input  logic                                pair_valid,
	output logic                                pair_ready,
	input  logic signed [dpf_pkg::DELTA_W-1:0]  delta_x,
	input  logic signed [dpf_pkg::DELTA_W-1:0]  delta_y,
	input  logic signed [dpf_pkg::DELTA_W-1:0]  delta_z,
	// Result channel.
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic                                accepted,
	output logic signed [dpf_pkg::DIST_W-1:0]   oriented_distance,
	// Configuration port.
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [dpf_pkg::PADDR_W-1:0]         paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);
	import dpf_pkg::*;

	// Stage 1 registers the masked deltas; 2 multiplies; 3 sums; 4 takes
	// the magnitude of the projection and starts the square root; 5 to 9
	// run the wide angle and cylinder tests; the root leaves stage 15 and
	// stage 16 is the output register.
	localparam int SQ_FIRST = 4;
	localparam int SQ_LAST = SQ_FIRST + SQRT_STAGES - 1;
	localparam int NST = SQ_LAST + 1;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [1:0]                dims_q;
	logic signed [DIR_W-1:0]   dir_x_q, dir_y_q, dir_z_q;
	logic [COS_W-1:0]          cos_min_q;
	logic [CYL_W-1:0]          cyl_radius_q;
	logic [BENCH_W-1:0]        bench_height_q;
	logic                      asymmetric_q;
	logic                      cfg_wr;
	reg_idx_t                  cfg_idx;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q <= 2'd3;
			dir_x_q <= 16'sd16384;
			dir_y_q <= '0;
			dir_z_q <= '0;
			cos_min_q <= '0;
			cyl_radius_q <= '0;
			bench_height_q <= '0;
			asymmetric_q <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_DIMS:  dims_q <= pwdata[1:0];
				REG_DIR_X: dir_x_q <= pwdata[DIR_W-1:0];
				REG_DIR_Y: dir_y_q <= pwdata[DIR_W-1:0];
				REG_DIR_Z: dir_z_q <= pwdata[DIR_W-1:0];
				REG_COS:   cos_min_q <= pwdata[COS_W-1:0];
				REG_CYL:   cyl_radius_q <= pwdata[CYL_W-1:0];
				REG_BENCH: bench_height_q <= pwdata[BENCH_W-1:0];
				REG_ASYM:  asymmetric_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_DIMS:  prdata = 32'(dims_q);
			REG_DIR_X: prdata = 32'(unsigned'(dir_x_q));
			REG_DIR_Y: prdata = 32'(unsigned'(dir_y_q));
			REG_DIR_Z: prdata = 32'(unsigned'(dir_z_q));
			REG_COS:   prdata = 32'(cos_min_q);
			REG_CYL:   prdata = 32'(cyl_radius_q);
			REG_BENCH: prdata = 32'(bench_height_q);
			REG_ASYM:  prdata = 32'(asymmetric_q);
			default:   prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Values derived from configuration only. The user must write while the
	// pipeline is empty; the block does not enforce it. These then settle
	// long before any pair reaches the stage that reads them.
	// ------------------------------------------------------------------
	logic [1:0] n_eff;
	logic use_y, use_z;
	logic signed [DIR_W-1:0] dirx_m, diry_m, dirz_m;
	logic signed [2*DIR_W-1:0] dsx, dsy, dsz;
	logic [COS_W-1:0] cos_sat;
	logic [2*COS_W-1:0] cos_sq;

	always_comb begin
		if (dims_q == 2'd0) begin
			n_eff = 2'd1;
		end else if (dims_q > 2'(MAX_DIMS)) begin
			n_eff = 2'(MAX_DIMS);
		end else begin
			n_eff = dims_q;
		end
	end

	assign use_y = (n_eff >= 2'd2);
	assign use_z = (n_eff >= 2'd3);
	assign dirx_m = dir_x_q;
	assign diry_m = use_y ? dir_y_q : '0;
	assign dirz_m = use_z ? dir_z_q : '0;
	assign dsx = dirx_m * dirx_m;
	assign dsy = diry_m * diry_m;
	assign dsz = dirz_m * dirz_m;
	assign cos_sat = (cos_min_q > 17'd65536) ? 17'd65536 : cos_min_q;
	assign cos_sq = cos_sat * cos_sat;

	logic [31:0] dn2_q;
	logic [32:0] cosq_q;
	logic [2*CYL_W-1:0] cylsq_q;
	logic [56:0] lim0_q, lim1_q;
	logic [81:0] lim_q;

	always_ff @(posedge clk) begin
		dn2_q <= 32'(unsigned'(dsx)) + 32'(unsigned'(dsy)) + 32'(unsigned'(dsz));
		cosq_q <= cos_sq[32:0];
		cylsq_q <= 50'(cyl_radius_q) * 50'(cyl_radius_q);
		lim0_q <= 57'(cylsq_q[CYL_W-1:0]) * 57'(dn2_q);
		lim1_q <= 57'(cylsq_q[2*CYL_W-1:CYL_W]) * 57'(dn2_q);
		lim_q <= 82'(lim0_q) + (82'(lim1_q) << CYL_W);
	end

	// ------------------------------------------------------------------
	// Pipeline valid bits and stall control. A stage advances when it is
	// empty or when the stage after it advances, so bubbles collapse and pairs
	// keep entering while a result waits at the output, until all stages fill.
	// ------------------------------------------------------------------
	logic [NST:1]   v_q;
	logic [NST+1:1] en;

	always_comb begin
		en[NST+1] = result_ready;
		for (int k = NST; k >= 1; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end

	assign pair_ready = en[1];
	assign result_valid = v_q[NST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[1]) begin
				v_q[1] <= pair_valid;
			end
			for (int k = 2; k <= NST; k++) begin
				if (en[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Datapath
	// ------------------------------------------------------------------
	logic signed [DELTA_W-1:0] dx_s1, dy_s1, dz_s1;
	logic [DELTA_W-1:0] alast_s1;
	logic signed [DELTA_W-1:0] last_in;
	logic [DELTA_W-1:0] last_abs;

	logic signed [39:0] px_s2, py_s2, pz_s2;
	logic [46:0] qx_s2, qy_s2, qz_s2;
	logic signed [47:0] sqx, sqy, sqz;
	logic bfail_s2, bfail_s3, bfail_s4, bfail_s5, bfail_s6, bfail_s7, bfail_s8;

	logic signed [41:0] dproj_s3;
	logic [NORM_W-1:0] dn1_s3, dn1_s4;

	logic [39:0] ap_s4;
	logic [41:0] dproj_mag;
	logic neg_s4, neg_s5, neg_s6, neg_s7, neg_s8;
	logic zero_s4, zero_s5, zero_s6, zero_s7, zero_s8;

	logic [55:0] pa0_s5, pa1_s5;
	logic [59:0] pb0_s5, pb1_s5;
	logic [79:0] prod_s6, dp2_s6, dp2_s7, dp2_s8;
	logic [80:0] prod_x;
	logic [59:0] pr0_s7, pr1_s7, pr2_s7;
	logic [79:0] orth_s7;
	logic [112:0] rhs_s8;
	logic cfail_s8;
	logic ok_s9, ng_s9;
	logic ok_s [SQ_LAST:SQ_FIRST+6];
	logic ng_s [SQ_LAST:SQ_FIRST+6];
	logic [ROOT_W-1:0] root;
	logic accepted_s16;
	logic signed [DIST_W-1:0] dist_s16;

	always_comb begin
		case (n_eff)
			2'd1:    last_in = delta_x;
			2'd2:    last_in = delta_y;
			default: last_in = delta_z;
		endcase
		// Negating the most negative value wraps to its correct magnitude.
		last_abs = last_in[DELTA_W-1] ? DELTA_W'(-last_in) : DELTA_W'(last_in);
	end

	assign sqx = dx_s1 * dx_s1;
	assign sqy = dy_s1 * dy_s1;
	assign sqz = dz_s1 * dz_s1;
	assign dproj_mag = dproj_s3[41] ? 42'(-dproj_s3) : 42'(dproj_s3);
	assign prod_x = {1'b0, prod_s6};

	always_ff @(posedge clk) begin
		// Stage 1: unused axes are forced to zero so they drop out of
		// every sum and test.
		if (en[1]) begin
			dx_s1 <= delta_x;
			dy_s1 <= use_y ? delta_y : '0;
			dz_s1 <= use_z ? delta_z : '0;
			alast_s1 <= last_abs;
		end
		// Stage 2: projection terms, squared deltas and the bench test.
		if (en[2]) begin
			px_s2 <= dx_s1 * dirx_m;
			py_s2 <= dy_s1 * diry_m;
			pz_s2 <= dz_s1 * dirz_m;
			qx_s2 <= sqx[46:0];
			qy_s2 <= sqy[46:0];
			qz_s2 <= sqz[46:0];
			bfail_s2 <= (bench_height_q != '0) && (alast_s1 > bench_height_q);
		end
		// Stage 3: projection and squared length.
		if (en[3]) begin
			dproj_s3 <= 42'(px_s2) + 42'(py_s2) + 42'(pz_s2);
			dn1_s3 <= 48'(qx_s2) + 48'(qy_s2) + 48'(qz_s2);
			bfail_s3 <= bfail_s2;
		end
		// Stage 4: projection magnitude and sign, and the zero-length flag.
		if (en[4]) begin
			ap_s4 <= dproj_mag[39:0];
			neg_s4 <= dproj_s3[41];
			zero_s4 <= (dn1_s3 == '0);
			dn1_s4 <= dn1_s3;
			bfail_s4 <= bfail_s3;
		end
		// Stage 5: partial products of |d|^2 |dir|^2 and dproj^2.
		if (en[5]) begin
			pa0_s5 <= 56'(dn1_s4[23:0]) * 56'(dn2_q);
			pa1_s5 <= 56'(dn1_s4[47:24]) * 56'(dn2_q);
			pb0_s5 <= 60'(ap_s4[19:0]) * 60'(ap_s4);
			pb1_s5 <= 60'(ap_s4[39:20]) * 60'(ap_s4);
			neg_s5 <= neg_s4;
			zero_s5 <= zero_s4;
			bfail_s5 <= bfail_s4;
		end
		// Stage 6: full products.
		if (en[6]) begin
			prod_s6 <= 80'(pa0_s5) + (80'(pa1_s5) << 24);
			dp2_s6 <= 80'(pb0_s5) + (80'(pb1_s5) << 20);
			neg_s6 <= neg_s5;
			zero_s6 <= zero_s5;
			bfail_s6 <= bfail_s5;
		end
		// Stage 7: cone threshold partials and the orthogonal term, which
		// cannot go negative.
		if (en[7]) begin
			pr0_s7 <= 60'(prod_x[26:0]) * 60'(cosq_q);
			pr1_s7 <= 60'(prod_x[53:27]) * 60'(cosq_q);
			pr2_s7 <= 60'(prod_x[80:54]) * 60'(cosq_q);
			orth_s7 <= prod_s6 - dp2_s6;
			dp2_s7 <= dp2_s6;
			neg_s7 <= neg_s6;
			zero_s7 <= zero_s6;
			bfail_s7 <= bfail_s6;
		end
		// Stage 8: cone threshold and cylinder test. The pair fails the
		// cylinder when its orthogonal term exceeds the radius limit.
		if (en[8]) begin
			rhs_s8 <= 113'(pr0_s7) + (113'(pr1_s7) << 27) + (113'(pr2_s7) << 54);
			cfail_s8 <= (cyl_radius_q != '0) && (82'(orth_s7) > lim_q);
			dp2_s8 <= dp2_s7;
			neg_s8 <= neg_s7;
			zero_s8 <= zero_s7;
			bfail_s8 <= bfail_s7;
		end
		// Stage 9: decision. A zero-length pair passes unconditionally.
		if (en[9]) begin
			ok_s9 <= zero_s8 || (!(113'({dp2_s8, 32'b0}) < rhs_s8) &&
				!cfail_s8 && !bfail_s8);
			ng_s9 <= !zero_s8 && neg_s8 && asymmetric_q &&
				!(113'({dp2_s8, 32'b0}) < rhs_s8) && !cfail_s8 && !bfail_s8;
		end
		// Decision rides along until the root is ready.
		if (en[SQ_FIRST + 6]) begin
			ok_s[SQ_FIRST + 6] <= ok_s9;
			ng_s[SQ_FIRST + 6] <= ng_s9;
		end
		for (int k = SQ_FIRST + 7; k <= SQ_LAST; k++) begin
			if (en[k]) begin
				ok_s[k] <= ok_s[k-1];
				ng_s[k] <= ng_s[k-1];
			end
		end
		// Output register. The root stays below 2^24, under the
		// saturation bound.
		if (en[NST]) begin
			accepted_s16 <= ok_s[SQ_LAST];
			dist_s16 <= ng_s[SQ_LAST] ? -DIST_W'(root) : DIST_W'(root);
		end
	end

	dpf_isqrt u_isqrt (
		.clk      (clk),
		.adv      (en[SQ_LAST:SQ_FIRST]),
		.rad_in   (dn1_s3),
		.root_out (root)
	);

	assign accepted = accepted_s16;
	assign oriented_distance = dist_s16;

endmodule

// File: rtl/dpf_checker.sv
// ----------------------------------------------------------------------------
// dpf_checker
// Port-level checks of the pair filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "directional_pair_filter_unit_assert.svh"

module dpf_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               pair_ready,
	input logic                               result_valid,
	input logic                               result_ready,
	input logic                               accepted,
	input logic signed [dpf_pkg::DIST_W-1:0]  oriented_distance
);
	import dpf_pkg::*;

	`DPF_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(accepted) && $stable(oriented_distance), "result beat changed while stalled")
	`DPF_ASSERT_SAME(a_stall_cause, !pair_ready, result_valid && !result_ready, "pair channel stalled without a blocked result")
	`DPF_ASSERT_SAME(a_reject_unsigned, result_valid && !accepted, !oriented_distance[DIST_W-1], "rejected pair carries a negative length")
	`DPF_ASSERT_SAME(a_dist_range, result_valid, oriented_distance != {1'b1, {(DIST_W-1){1'b0}}}, "length outside the saturation bound")

endmodule

bind directional_pair_filter_unit dpf_checker u_dpf_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.pair_ready        (pair_ready),
	.result_valid      (result_valid),
	.result_ready      (result_ready),
	.accepted          (accepted),
	.oriented_distance (oriented_distance)
);
